// ----- rtl/vln_pkg.sv -----
package vln_pkg;

    // component and arithmetic widths
    localparam int CW          = 16;                 // component width, Q8.8
    localparam int SUM_W       = 2 * CW;             // sum of squares, Q16.16
    localparam int FRAC_W      = 14;                 // unit fraction bits, Q1.14
    localparam int DIV_STEPS   = 2 * FRAC_W + 1;     // one quotient bit per stage
    localparam int QUO_W       = DIV_STEPS;          // |c|^2 * 2^28 / s <= 2^28
    localparam int RAD_W       = SUM_W;              // square root radicand
    localparam int ROOT_W      = RAD_W / 2;          // one root bit per stage
    localparam int REM_W       = ROOT_W + 2;
    localparam int OUT_W       = 16;
    localparam int LANE_LAT    = DIV_STEPS + ROOT_W; // lane depth, divide plus root stages
    localparam int PIPE_DEPTH  = 3 + LANE_LAT + 1;   // input, square, sum, lane, merge
    localparam int IN_TDATA_W  = ((3 * CW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;

    // what a lane hands to the merge stage
    typedef struct packed {
        logic              neg;
        logic [ROOT_W-1:0] mag;
    } lane_res_t;

endpackage

// ----- rtl/vln_isqrt.sv -----
module vln_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [vln_pkg::RAD_W-1:0]  rad,
    output logic [vln_pkg::ROOT_W-1:0] root
);
    import vln_pkg::*;

    // one root bit per stage, restoring form
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];

    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        for (int i = 0; i < ROOT_W; i++) begin
            if (i == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end else begin
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
                rad_in  = rad_reg[i-1];
            end
            rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next[i]  = REM_W'(rem_sh - trial);
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[i]  = rem_sh[REM_W-1:0];
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[i] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ROOT_W; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ----- rtl/vln_lane.sv -----
module vln_lane (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [vln_pkg::SUM_W-1:0] sq,
    input  logic [vln_pkg::SUM_W-1:0] sum,
    input  logic                      neg,
    output vln_pkg::lane_res_t        res
);
    import vln_pkg::*;

    // quotient floor(sq * 2^28 / sum), integer bit first, then fraction bits
    logic [SUM_W-1:0] rem_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic [SUM_W-1:0] div_reg [DIV_STEPS];
    logic             neg_reg [LANE_LAT];

    logic [SUM_W-1:0] rem_next [DIV_STEPS];
    logic [QUO_W-1:0] quo_next [DIV_STEPS];

    always_comb begin
        logic [SUM_W:0]   rem_sh;
        logic [SUM_W-1:0] d;
        logic [QUO_W-1:0] q_in;
        logic             ge;
        for (int i = 0; i < DIV_STEPS; i++) begin
            if (i == 0) begin
                rem_sh = {1'b0, sq};
                d      = sum;
                q_in   = '0;
            end else begin
                rem_sh = {rem_reg[i-1], 1'b0};
                d      = div_reg[i-1];
                q_in   = quo_reg[i-1];
            end
            ge          = rem_sh >= {1'b0, d};
            rem_next[i] = ge ? SUM_W'(rem_sh - {1'b0, d}) : rem_sh[SUM_W-1:0];
            quo_next[i] = {q_in[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
            div_reg[0] <= sum;
            for (int i = 1; i < DIV_STEPS; i++) begin
                div_reg[i] <= div_reg[i-1];
            end
            neg_reg[0] <= neg;
            for (int i = 1; i < LANE_LAT; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    logic [ROOT_W-1:0] root;

    vln_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (RAD_W'(quo_reg[DIV_STEPS-1])),
        .root (root)
    );

    assign res.neg = neg_reg[LANE_LAT-1];
    assign res.mag = root;

endmodule

// ----- rtl/vector_length_normalize.sv -----
// Vector length and normalization, fully pipelined.
//
// Input channel s_*: one request per accepted beat, three signed Q8.8
// components in s_tdata. Output channel m_*: one result per request, in
// order: length (unsigned Q8.8, truncated square root) and three signed
// Q1.14 unit components in m_tdata, zero-vector flag in m_tuser.
//
// A request passes 49 register stages: input register, squares, sum,
// 29 restoring divide stages (one quotient bit each) and 16 square root
// stages (one root bit each) per lane, then the merge register. The input
// register loads at the accepting edge. Throughput is one request per cycle
// while the receiver does not stall. Three identical lanes (x, y, z) run
// side by side; the length root runs beside them and is delayed to match.
//
// A zero vector gives length 0, units 0 and m_tuser = 1.
// Reset clears all valid bits; the data path holds no reset.
// When the receiver stalls, the whole pipeline holds and s_tready drops.
module vector_length_normalize (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // comp_x [15:0], comp_y [31:16], comp_z [47:32]
    input  logic [vln_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // vec_length [15:0], unit_x [31:16], unit_y [47:32], unit_z [63:48]
    output logic [vln_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // zero_length [0]
    output logic                              m_tuser
);
    import vln_pkg::*;

    // whole pipeline advances together
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // stage A: capture components
    logic signed [CW-1:0] cx_a_reg, cy_a_reg, cz_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_a_reg <= s_tdata[CW-1:0];
            cy_a_reg <= s_tdata[2*CW-1:CW];
            cz_a_reg <= s_tdata[3*CW-1:2*CW];
        end
    end

    // stage B: magnitudes squared
    logic [CW-1:0]    mx, my, mz;
    logic [SUM_W-1:0] sqx_b_reg, sqy_b_reg, sqz_b_reg;
    logic [2:0]       neg_b_reg;

    assign mx = cx_a_reg[CW-1] ? CW'(-cx_a_reg) : CW'(cx_a_reg);
    assign my = cy_a_reg[CW-1] ? CW'(-cy_a_reg) : CW'(cy_a_reg);
    assign mz = cz_a_reg[CW-1] ? CW'(-cz_a_reg) : CW'(cz_a_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_b_reg <= SUM_W'(mx) * SUM_W'(mx);
            sqy_b_reg <= SUM_W'(my) * SUM_W'(my);
            sqz_b_reg <= SUM_W'(mz) * SUM_W'(mz);
            neg_b_reg <= {cz_a_reg[CW-1], cy_a_reg[CW-1], cx_a_reg[CW-1]};
        end
    end

    // stage C: sum of squares (fits SUM_W bits), zero detect
    logic [SUM_W-1:0] sqx_c_reg, sqy_c_reg, sqz_c_reg, sum_c_reg;
    logic [2:0]       neg_c_reg;
    logic             zero_c_reg;
    logic [SUM_W-1:0] sum_next;

    assign sum_next = sqx_b_reg + sqy_b_reg + sqz_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_c_reg  <= sqx_b_reg;
            sqy_c_reg  <= sqy_b_reg;
            sqz_c_reg  <= sqz_b_reg;
            sum_c_reg  <= sum_next;
            neg_c_reg  <= neg_b_reg;
            zero_c_reg <= (sum_next == '0);
        end
    end

    // lanes: unit magnitude = isqrt(floor(sq * 2^28 / sum))
    lane_res_t res_x, res_y, res_z;

    vln_lane u_lane_x (
        .aclk (aclk), .en (en), .sq (sqx_c_reg), .sum (sum_c_reg),
        .neg  (neg_c_reg[0]), .res (res_x)
    );
    vln_lane u_lane_y (
        .aclk (aclk), .en (en), .sq (sqy_c_reg), .sum (sum_c_reg),
        .neg  (neg_c_reg[1]), .res (res_y)
    );
    vln_lane u_lane_z (
        .aclk (aclk), .en (en), .sq (sqz_c_reg), .sum (sum_c_reg),
        .neg  (neg_c_reg[2]), .res (res_z)
    );

    // length root, then delayed to line up with the lanes
    logic [ROOT_W-1:0] len_root;
    logic [ROOT_W-1:0] len_dly_reg  [DIV_STEPS];
    logic              zero_dly_reg [LANE_LAT];

    vln_isqrt u_len_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sum_c_reg),
        .root (len_root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            len_dly_reg[0] <= len_root;
            for (int i = 1; i < DIV_STEPS; i++) begin
                len_dly_reg[i] <= len_dly_reg[i-1];
            end
            zero_dly_reg[0] <= zero_c_reg;
            for (int i = 1; i < LANE_LAT; i++) begin
                zero_dly_reg[i] <= zero_dly_reg[i-1];
            end
        end
    end

    // merge: apply signs, force zeros for the zero vector
    logic [OUT_W-1:0] len_out_reg, ux_out_reg, uy_out_reg, uz_out_reg;
    logic             zero_out_reg;
    logic             zl;

    function automatic logic [OUT_W-1:0] apply_sign(lane_res_t r);
        logic [OUT_W-1:0] m;
        m = OUT_W'(r.mag);
        return r.neg ? OUT_W'(-m) : m;
    endfunction

    assign zl = zero_dly_reg[LANE_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_out_reg <= zl;
            len_out_reg  <= zl ? '0 : OUT_W'(len_dly_reg[DIV_STEPS-1]);
            ux_out_reg   <= zl ? '0 : apply_sign(res_x);
            uy_out_reg   <= zl ? '0 : apply_sign(res_y);
            uz_out_reg   <= zl ? '0 : apply_sign(res_z);
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = OUT_TDATA_W'({uz_out_reg, uy_out_reg, ux_out_reg, len_out_reg});
    assign m_tuser  = zero_out_reg;

    // zero vector gives all-zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector with nonzero data");

    // any nonzero vector has length at least one LSB
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> len_out_reg != '0)
        else $error("nonzero vector with zero length");

    // unit components stay within +/- 1.0
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(ux_out_reg) <= 16384 && $signed(ux_out_reg) >= -16384
                   && $signed(uy_out_reg) <= 16384 && $signed(uy_out_reg) >= -16384
                   && $signed(uz_out_reg) <= 16384 && $signed(uz_out_reg) >= -16384))
        else $error("unit component out of range");

endmodule
